// ===== design/hkv_pkg.sv =====
// hkv_pkg: shared types and constants of the hashed key-value map
// operation codes, controller states and fixed field widths
// no dependencies
`default_nettype none

package hkv_pkg;

    // fixed field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;
    localparam int OP_W   = 2;

    // operation codes; the fourth code is a no-op
    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } state_t;

endpackage

`default_nettype wire

// ===== design/hkv_bucket_ram.sv =====
// hkv_bucket_ram: bucket row memory, one write port and one registered read port
// each row holds the valid bits, keys and data of all ways of one bucket
// no dependencies
`default_nettype none

module hkv_bucket_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int ROW_W  = 260
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [ROW_W-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/hkv_way_select.sv =====
// hkv_way_select: compares the ways of one bucket row with a key
// gives the matching way and the lowest free way; uses hkv_pkg
`default_nettype none

module hkv_way_select
    import hkv_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int WAY_W = 2
) (
    input  wire logic [WAYS-1:0]            valid,
    input  wire logic [WAYS-1:0][KEY_W-1:0] keys,
    input  wire logic [KEY_W-1:0]           key,
    output logic      [WAYS-1:0]            match_mask,
    output logic                            hit,
    output logic      [WAY_W-1:0]           hit_way,
    output logic                            has_free,
    output logic      [WAY_W-1:0]           free_way
);

    // per-way key compare
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match_mask[w] = valid[w] && (keys[w] == key);
        end
    end

    // lowest matching way and lowest free way
    always_comb
    begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match_mask[w])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid[w])
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hashed_key_value_map.sv =====
// Hashed key-value map: put, get and remove on 32-bit keys, bucket = key mod BUCKETS.
// The result word is registered after the bucket row read and the lookup step;
// a result word still held at the output stalls the lookup and the input.
// A new word is taken only after the last one has left the lookup and write-back.
// Reset: a clearing pass writes every bucket row with in_ready low;
// entry count starts at zero.
`default_nettype none

module hashed_key_value_map
    import hkv_pkg::*;
#(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [KEY_W-1:0]  lookup_key,
    input  wire logic [DATA_W-1:0] store_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [DATA_W-1:0] result_data,
    output logic                   found,
    output logic                   refused,
    output logic      [CNT_W-1:0]  entry_count
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (1 + KEY_W + DATA_W);

    state_t state_reg, state_next;

    logic [BKT_W-1:0]  clr_addr_reg, clr_addr_next;
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] result_reg;
    logic              found_reg;
    logic              refused_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;

    // memory ports
    logic              mem_we;
    logic [BKT_W-1:0]  mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  mem_rdata;

    // unpacked bucket rows
    logic [WAYS-1:0]             rd_valid;
    logic [WAYS-1:0][KEY_W-1:0]  rd_key;
    logic [WAYS-1:0][DATA_W-1:0] rd_data;
    logic [WAYS-1:0]             wr_valid;
    logic [WAYS-1:0][KEY_W-1:0]  wr_key;
    logic [WAYS-1:0][DATA_W-1:0] wr_data;

    // way compare results
    logic [WAYS-1:0]  match_mask;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             has_free;
    logic [WAY_W-1:0] free_way;

    // lookup outcome
    logic              row_mod;
    logic [DATA_W-1:0] res_comb;
    logic              found_comb;
    logic              refused_comb;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign {rd_valid, rd_key, rd_data} = mem_rdata;

    hkv_bucket_ram #(
        .DEPTH  (BUCKETS),
        .ADDR_W (BKT_W),
        .ROW_W  (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (lookup_key[BKT_W-1:0]),
        .rdata (mem_rdata)
    );

    hkv_way_select #(
        .WAYS  (WAYS),
        .WAY_W (WAY_W)
    ) u_sel (
        .valid      (rd_valid),
        .keys       (rd_key),
        .key        (key_reg),
        .match_mask (match_mask),
        .hit        (hit),
        .hit_way    (hit_way),
        .has_free   (has_free),
        .free_way   (free_way)
    );

    // modify the bucket row for the current word
    always_comb
    begin
        wr_valid     = rd_valid;
        wr_key       = rd_key;
        wr_data      = rd_data;
        row_mod      = 1'b0;
        res_comb     = '0;
        found_comb   = 1'b0;
        refused_comb = 1'b0;
        count_next   = count_reg;
        case (op_reg)
            OP_PUT:
            begin
                found_comb = hit;
                if (val_reg == '0)
                begin
                    refused_comb = 1'b1;
                end
                else if (hit)
                begin
                    res_comb         = rd_data[hit_way];
                    wr_data[hit_way] = val_reg;
                    row_mod          = 1'b1;
                end
                else if (has_free)
                begin
                    wr_valid[free_way] = 1'b1;
                    wr_key[free_way]   = key_reg;
                    wr_data[free_way]  = val_reg;
                    row_mod            = 1'b1;
                    count_next         = count_reg + CNT_W'(1);
                end
                else
                begin
                    refused_comb = 1'b1;
                end
            end
            OP_GET:
            begin
                found_comb = hit;
                if (hit)
                begin
                    res_comb = rd_data[hit_way];
                end
            end
            OP_REMOVE:
            begin
                found_comb = hit;
                if (hit)
                begin
                    res_comb          = rd_data[hit_way];
                    wr_valid[hit_way] = 1'b0;
                    row_mod           = 1'b1;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                found_comb = 1'b0;
            end
        endcase
    end

    // controller: clearing pass, idle, row lookup and write-back
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        in_ready      = 1'b0;
        load_out      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = key_reg[BKT_W-1:0];
        mem_wdata     = {wr_valid, wr_key, wr_data};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + BKT_W'(1);
                if (clr_addr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    mem_we     = row_mod;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                count_reg <= count_next;
            end
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(operation);
            key_reg <= lookup_key;
            val_reg <= store_value;
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg      <= res_comb;
            found_reg       <= found_comb;
            refused_reg     <= refused_comb;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_data = result_reg;
    assign found       = found_reg;
    assign refused     = refused_reg;
    assign entry_count = entry_count_reg;

`ifndef NO_ASSERTIONS
    // an accepted word always goes to the row lookup
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted word did not start a lookup");

    // a new result only comes out of a lookup
    a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result appeared without a lookup");

    // the entry count moves only on write-back of a lookup
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(load_out))
        else $error("entry count changed outside a lookup");

    // a key is never stored in two ways of a bucket
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOOKUP |-> $onehot0(match_mask))
        else $error("key matches more than one way");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench for the hashed key-value map (put, get, remove)
// drives random and directed words, predicts every result and compares field by field
// depends on hkv_pkg and hashed_key_value_map

module tb;
    import hkv_pkg::*;

    localparam int BUCKETS          = 256;
    localparam int WAYS             = 4;
    localparam int SLOTS            = BUCKETS * WAYS;
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int RANDOM_ITEMS     = 780;
    localparam int HOT_BUCKETS      = 5;
    localparam int HOT_KEYS         = 24;
    localparam int CALM_ITEMS       = 120;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 250000;

    // one request word as offered on the input channel
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        bit                wait_idle;
    } map_req_t;

    // one result word
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              hit;
        logic              rejected;
        logic [CNT_W-1:0]  count;
    } map_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [OP_W-1:0] operation = '0;
    logic [KEY_W-1:0] lookup_key = '0;
    logic [DATA_W-1:0] store_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [DATA_W-1:0] result_data;
    logic found;
    logic refused;
    logic [CNT_W-1:0] entry_count;

    // predicted map contents
    bit                slot_used [SLOTS];
    logic [KEY_W-1:0]  slot_key [SLOTS];
    logic [DATA_W-1:0] slot_data [SLOTS];
    int                stored = 0;

    map_req_t    ops_to_send [$];
    map_result_t results_due [$];
    int          total_items = 0;
    int          taken_cnt = 0;
    int          result_cnt = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    logic        in_taken = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          long_hold_done = 1'b0;

    hashed_key_value_map #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .lookup_key  (lookup_key),
        .store_value (store_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_data (result_data),
        .found       (found),
        .refused     (refused),
        .entry_count (entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one operation to the predicted map and return its result
    function automatic map_result_t next_map_result(input logic [OP_W-1:0] op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [DATA_W-1:0] value);
        map_result_t r;
        int base;
        int hit;
        int free_way;
        r = '0;
        base = int'(key % BUCKETS) * WAYS;
        hit = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++)
        begin
            if (slot_used[base + w] && slot_key[base + w] == key && hit < 0)
                hit = base + w;
            if (!slot_used[base + w] && free_way < 0)
                free_way = base + w;
        end
        case (op)
            OP_PUT:
            begin
                r.hit = (hit >= 0);
                if (value == '0)
                    r.rejected = 1'b1;
                else if (hit >= 0)
                begin
                    r.data = slot_data[hit];
                    slot_data[hit] = value;
                end
                else if (free_way >= 0)
                begin
                    slot_used[free_way] = 1'b1;
                    slot_key[free_way] = key;
                    slot_data[free_way] = value;
                    stored++;
                end
                else
                    r.rejected = 1'b1;
            end
            OP_GET:
            begin
                r.hit = (hit >= 0);
                if (hit >= 0)
                    r.data = slot_data[hit];
            end
            OP_REMOVE:
            begin
                r.hit = (hit >= 0);
                if (hit >= 0)
                begin
                    r.data = slot_data[hit];
                    slot_used[hit] = 1'b0;
                    stored--;
                end
            end
            default:
            begin
                // no-op code leaves the map alone
            end
        endcase
        r.count = CNT_W'(stored);
        return r;
    endfunction

    function automatic bit winding_down();
        return taken_cnt + CALM_ITEMS >= total_items;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in result %0d, %s: got %h, expected %h",
                 result_cnt, what, got, want);
        errors++;
    endtask

    task automatic add_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] value, input bit wait_idle);
        map_req_t r;
        r.op = op;
        r.key = key;
        r.value = value;
        r.wait_idle = wait_idle;
        ops_to_send.push_back(r);
    endtask

    // driver: offers the next word at the falling edge, holds it until taken
    always @(negedge clk)
    begin
        map_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_taken))
        begin
            if (!winding_down() && send_gap == 0 && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 18);
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (ops_to_send.size() > 0 &&
                     !(ops_to_send[0].wait_idle && results_due.size() != 0))
            begin
                nxt = ops_to_send.pop_front();
                in_valid <= 1'b1;
                operation <= nxt.op;
                lookup_key <= nxt.key;
                store_value <= nxt.value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus one long hold that backs the block up
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (!long_hold_done && taken_cnt >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            else if (!winding_down() && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: check the result word first, then predict for the accepted word
    always @(posedge clk)
    begin
        map_result_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected word", result_data, '0);
                else
                begin
                    want = results_due.pop_front();
                    if (result_data !== want.data)
                        report_mismatch("result_data", result_data, want.data);
                    if (found !== want.hit)
                        report_mismatch("found", 32'(found), 32'(want.hit));
                    if (refused !== want.rejected)
                        report_mismatch("refused", 32'(refused), 32'(want.rejected));
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
                end
                result_cnt++;
            end
            if (in_valid && in_ready)
            begin
                results_due.push_back(next_map_result(operation, lookup_key, store_value));
                taken_cnt++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [7:0]        hot_bucket [HOT_BUCKETS];
        logic [KEY_W-1:0]  hot_key [HOT_KEYS];
        logic [31:0]       r;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        int                sel;

        // directed: empty map, zero data, overwrite, full bucket, lowest free way
        add_req(OP_GET,    32'h0000_0000, 32'h1234_5678, 1'b0);
        add_req(OP_PUT,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PUT,    32'h0000_0000, 32'h0000_0001, 1'b0);
        add_req(OP_PUT,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PUT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_GET,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_PUT,    32'h0000_0100, 32'h0000_0100, 1'b0);
        add_req(OP_PUT,    32'h0000_0200, 32'h0000_0200, 1'b0);
        add_req(OP_PUT,    32'h0000_0300, 32'h0000_0300, 1'b0);
        add_req(OP_PUT,    32'h0000_0400, 32'h0000_0400, 1'b0);
        add_req(OP_REMOVE, 32'h0000_0100, 32'h0000_0000, 1'b0);
        add_req(OP_PUT,    32'h0000_0400, 32'hAAAA_5555, 1'b0);
        add_req(OP_GET,    32'h0000_0400, 32'h0000_0000, 1'b0);
        add_req(OP_GET,    32'h0000_0100, 32'h0000_0000, 1'b0);
        add_req(OP_PUT,    32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
        add_req(OP_PUT,    32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
        add_req(OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        add_req(OP_NOP,    32'h0000_0000, 32'h0000_0000, 1'b0);
        add_req(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0);

        // a few hot buckets, most shared by more keys than there are ways
        for (int i = 0; i < HOT_BUCKETS; i++)
            hot_bucket[i] = 8'($urandom_range(0, BUCKETS - 1));
        hot_bucket[0] = 8'hFF;
        for (int i = 0; i < HOT_KEYS; i++)
        begin
            r = $urandom;
            hot_key[i] = {r[31:8], hot_bucket[i % HOT_BUCKETS]};
        end

        // random words, mostly on hot keys; pause for an empty pipe now and then
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                op = OP_PUT;
            else if (sel < 75)
                op = OP_GET;
            else if (sel < 98)
                op = OP_REMOVE;
            else
                op = OP_NOP;
            if ($urandom_range(0, 3) == 0)
                key = $urandom;
            else
                key = hot_key[$urandom_range(0, HOT_KEYS - 1)];
            sel = $urandom_range(0, 99);
            if (sel < 5)
                value = '0;
            else if (sel < 8)
                value = '1;
            else
                value = $urandom;
            add_req(op, key, value, (n % 250) == 0);
        end
        total_items = ops_to_send.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (taken_cnt != total_items || results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
